// ===== sv/mdcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mdcr_pkg
// shared types, constants and md5 round helpers for the checker
// ---------------------------------------------------------------------------
package mdcr_pkg;

  localparam int MAX_KEY_BYTES  = 32;
  localparam int MAX_USER_BYTES = 32;
  localparam int ROUNDS         = 64;
  localparam int TAG_W          = 7;

  // side payload of one compression pipeline: tag, two-block flag, upper block
  localparam int SIDE_W         = TAG_W + 1 + 512;
  // side payload of one round stage: block side payload plus chaining input
  localparam int RSIDE_W        = SIDE_W + 128;

  typedef logic [31:0] word_t;
  typedef logic [511:0] block_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } md_state_t;

  typedef enum logic [2:0] {
    REG_USER0   = 3'd0,
    REG_USER1   = 3'd1,
    REG_USER2   = 3'd2,
    REG_USER3   = 3'd3,
    REG_ULEN    = 3'd4,
    REG_SALT    = 3'd5,
    REG_TGT_LO  = 3'd6,
    REG_TGT_HI  = 3'd7
  } cfg_reg_t;

  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hefcdab89;
  localparam word_t IV_C = 32'h98badcfe;
  localparam word_t IV_D = 32'h10325476;

  function automatic word_t md_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md_g(input logic [5:0] i);
    logic [3:0] g;
    logic [7:0] t;
    t = 8'd0;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: begin t = 8'd5 * {2'b00, i} + 8'd1; g = t[3:0]; end
      2'd2: begin t = 8'd3 * {2'b00, i} + 8'd5; g = t[3:0]; end
      default: begin t = 8'd7 * {2'b00, i}; g = t[3:0]; end
    endcase
    return g;
  endfunction

  function automatic md_state_t md_round(input md_state_t s, input block_t m,
                                         input logic [5:0] i);
    word_t f, t, w;
    logic [3:0] g;
    logic [4:0] sh;
    md_state_t r;
    case (i[5:4])
      2'd0: f = (s.b & s.c) | (~s.b & s.d);
      2'd1: f = (s.d & s.b) | (~s.d & s.c);
      2'd2: f = s.b ^ s.c ^ s.d;
      default: f = s.c ^ (s.b | ~s.d);
    endcase
    g = md_g(i);
    sh = md_s(i);
    w = m[32*g +: 32];
    t = s.a + f + md_k(i) + w;
    r.a = s.d;
    r.d = s.c;
    r.c = s.b;
    r.b = s.b + ((t << sh) | (t >> (6'd32 - {1'b0, sh})));
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction

endpackage
`default_nettype wire

// ===== sv/md5_challenge_response_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// md5_challenge_response_checker_top
// salted double md5 checker: md5(hex(md5(key || user)) || salt)
//
// in_* carries one candidate key per item with its tag; out_* returns the
// final digest, the tag and a match flag against the target registers.
// cfg_* writes the user name, user length, salt and target; write only
// while the pipeline is empty.
// three md5 compressions run back to back as 64-stage round pipelines:
// first and second block of the key/user message, then the hex/salt block.
// an item is accepted every cycle while in_ready is high; it passes 1 + 3*64 + 1
// = 194 registers: the input register, one per md5 round, and the output register.
// a block-long first message (over 55 bytes) runs its second block in the
// middle pipeline; shorter messages pass it with the chaining result
// forwarded unchanged.
// the whole pipeline advances only when the output register is free or
// taken, so a stall on out_ready holds every stage and nothing is lost.
// reset clears all valid bits and the configuration registers.
// ---------------------------------------------------------------------------
module md5_challenge_response_checker_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [63:0]  in_key_bytes_0_7,
  input  wire logic [63:0]  in_key_bytes_8_15,
  input  wire logic [63:0]  in_key_bytes_16_23,
  input  wire logic [63:0]  in_key_bytes_24_31,
  input  wire logic [5:0]   in_key_length,
  input  wire logic [6:0]   in_candidate_index,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [6:0]        out_result_index,
  output logic [63:0]       out_digest_low,
  output logic [63:0]       out_digest_high,
  output logic              out_is_match,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  localparam int TW = mdcr_pkg::TAG_W;

  logic [255:0] user_r;
  logic [5:0]   ulen_r;
  logic [31:0]  salt_r;
  logic [127:0] tgt_r;

  logic en;
  logic out_valid_r;
  logic [6:0] out_idx_r;
  logic [127:0] out_dig_r;
  logic out_match_r;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_r <= '0;
      ulen_r <= '0;
      salt_r <= '0;
      tgt_r  <= '0;
    end else if (cfg_valid) begin
      case (mdcr_pkg::cfg_reg_t'(cfg_index))
        mdcr_pkg::REG_USER0:  user_r[63:0]    <= cfg_data;
        mdcr_pkg::REG_USER1:  user_r[127:64]  <= cfg_data;
        mdcr_pkg::REG_USER2:  user_r[191:128] <= cfg_data;
        mdcr_pkg::REG_USER3:  user_r[255:192] <= cfg_data;
        mdcr_pkg::REG_ULEN:   ulen_r <= cfg_data[5:0];
        mdcr_pkg::REG_SALT:   salt_r <= cfg_data[31:0];
        mdcr_pkg::REG_TGT_LO: tgt_r[63:0]   <= cfg_data;
        mdcr_pkg::REG_TGT_HI: tgt_r[127:64] <= cfg_data;
        default: ;
      endcase
    end
  end

  // message build: key || user || 0x80 || zeros || bit length
  logic [255:0] key_w;
  logic [5:0] klen, ulen;
  logic [6:0] nlen;
  logic [1023:0] msg;
  logic two_blk;

  assign key_w = {in_key_bytes_24_31, in_key_bytes_16_23, in_key_bytes_8_15,
                  in_key_bytes_0_7};
  assign klen = (in_key_length > 6'(mdcr_pkg::MAX_KEY_BYTES)) ?
                6'(mdcr_pkg::MAX_KEY_BYTES) : in_key_length;
  assign ulen = (ulen_r > 6'(mdcr_pkg::MAX_USER_BYTES)) ?
                6'(mdcr_pkg::MAX_USER_BYTES) : ulen_r;
  assign nlen = {1'b0, klen} + {1'b0, ulen};
  assign two_blk = nlen > 7'd55;

  always_comb begin
    msg = '0;
    for (int i = 0; i < 32; i++) begin
      if (6'(i) < klen) msg[8*i +: 8] = key_w[8*i +: 8];
    end
    for (int j = 0; j < 32; j++) begin
      if (6'(j) < ulen) msg[8*({1'b0, klen} + 7'(j)) +: 8] = user_r[8*j +: 8];
    end
    msg[8*nlen +: 8] = 8'h80;
    if (two_blk) msg[1023:960] = {54'd0, nlen, 3'd0};
    else         msg[511:448]  = {54'd0, nlen, 3'd0};
  end

  // input register
  logic          s0_vld_r;
  logic [1023:0] s0_msg_r;
  logic          s0_two_r;
  logic [TW-1:0] s0_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_msg_r <= msg;
      s0_two_r <= two_blk;
      s0_idx_r <= in_candidate_index;
    end
  end

  mdcr_pkg::md_state_t iv;
  assign iv = '{a: mdcr_pkg::IV_A, b: mdcr_pkg::IV_B, c: mdcr_pkg::IV_C,
                d: mdcr_pkg::IV_D};

  logic          b1_vld;
  mdcr_pkg::md_state_t b1_h;
  logic [mdcr_pkg::SIDE_W-1:0] b1_side;

  mdcr_block u_blk1 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s0_vld_r), .h_i(iv),
    .blk_i(s0_msg_r[511:0]), .side_i({s0_idx_r, s0_two_r, s0_msg_r[1023:512]}),
    .vld_o(b1_vld), .h_o(b1_h), .side_o(b1_side)
  );

  localparam int S2W = TW + 1 + 128;
  logic          b2_vld;
  mdcr_pkg::md_state_t b2_h;
  logic [mdcr_pkg::SIDE_W-1:0] b2_side;
  logic          two_w;

  assign two_w = b1_side[512];

  mdcr_block u_blk2 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(b1_vld), .h_i(b1_h),
    .blk_i(b1_side[511:0]),
    .side_i({{(mdcr_pkg::SIDE_W-S2W){1'b0}}, b1_side[mdcr_pkg::SIDE_W-1:513], two_w, b1_h}),
    .vld_o(b2_vld), .h_o(b2_h), .side_o(b2_side)
  );

  mdcr_pkg::md_state_t d1;
  logic [127:0] d1_bytes;
  logic [511:0] blk3;

  assign d1 = b2_side[128] ? b2_h : mdcr_pkg::md_state_t'(b2_side[127:0]);
  assign d1_bytes = {d1.d, d1.c, d1.b, d1.a};

  always_comb begin
    blk3 = '0;
    for (int i = 0; i < 16; i++) begin
      blk3[16*i +: 8]     = mdcr_pkg::hex_char(d1_bytes[8*i+4 +: 4]);
      blk3[16*i+8 +: 8]   = mdcr_pkg::hex_char(d1_bytes[8*i +: 4]);
    end
    blk3[287:256] = salt_r;
    blk3[295:288] = 8'h80;
    blk3[511:448] = 64'd288;
  end

  logic          b3_vld;
  mdcr_pkg::md_state_t b3_h;
  logic [mdcr_pkg::SIDE_W-1:0] b3_side;
  logic [TW-1:0] b3_idx;

  mdcr_block u_blk3 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(b2_vld), .h_i(iv),
    .blk_i(blk3),
    .side_i({{(mdcr_pkg::SIDE_W-TW){1'b0}}, b2_side[S2W-1:129]}),
    .vld_o(b3_vld), .h_o(b3_h), .side_o(b3_side)
  );

  assign b3_idx = b3_side[TW-1:0];

  logic [127:0] dig;
  assign dig = {b3_h.d, b3_h.c, b3_h.b, b3_h.a};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r   <= b3_idx;
      out_dig_r   <= dig;
      out_match_r <= (dig == tgt_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_digest_low   = out_dig_r[63:0];
  assign out_digest_high  = out_dig_r[127:64];
  assign out_is_match     = out_match_r;

endmodule
`default_nettype wire

// ===== sv/mdcr_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mdcr_round
// one registered md5 round stage with valid, stall and side payload
// ---------------------------------------------------------------------------
module mdcr_round (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic [5:0]                         rnd_i,
  input  wire logic                               vld_i,
  input  wire mdcr_pkg::md_state_t                st_i,
  input  wire mdcr_pkg::block_t                   blk_i,
  input  wire logic [mdcr_pkg::RSIDE_W-1:0]       side_i,
  output logic                                    vld_o,
  output mdcr_pkg::md_state_t                     st_o,
  output mdcr_pkg::block_t                        blk_o,
  output logic [mdcr_pkg::RSIDE_W-1:0]            side_o
);

  logic                              vld_r;
  mdcr_pkg::md_state_t               st_r, st_nxt;
  mdcr_pkg::block_t                  blk_r;
  logic [mdcr_pkg::RSIDE_W-1:0]      side_r;

  assign st_nxt = mdcr_pkg::md_round(st_i, blk_i, rnd_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r   <= st_nxt;
      blk_r  <= blk_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign st_o   = st_r;
  assign blk_o  = blk_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

// ===== sv/mdcr_block.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mdcr_block
// 64-stage md5 compression with chaining add on the final stage output
// ---------------------------------------------------------------------------
module mdcr_block (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               vld_i,
  input  wire mdcr_pkg::md_state_t                h_i,
  input  wire mdcr_pkg::block_t                   blk_i,
  input  wire logic [mdcr_pkg::SIDE_W-1:0]        side_i,
  output logic                                    vld_o,
  output mdcr_pkg::md_state_t                     h_o,
  output logic [mdcr_pkg::SIDE_W-1:0]             side_o
);

  logic                            vld_w  [mdcr_pkg::ROUNDS+1];
  mdcr_pkg::md_state_t             st_w   [mdcr_pkg::ROUNDS+1];
  mdcr_pkg::block_t                blk_w  [mdcr_pkg::ROUNDS+1];
  logic [mdcr_pkg::RSIDE_W-1:0]    side_w [mdcr_pkg::ROUNDS+1];
  mdcr_pkg::md_state_t             h_last;

  assign vld_w[0]  = vld_i;
  assign st_w[0]   = h_i;
  assign blk_w[0]  = blk_i;
  assign side_w[0] = {h_i, side_i};

  for (genvar r = 0; r < mdcr_pkg::ROUNDS; r++) begin : g_rnd
    mdcr_round u_rnd (
      .clk(clk), .rst_n(rst_n), .en(en), .rnd_i(6'(r)),
      .vld_i(vld_w[r]), .st_i(st_w[r]), .blk_i(blk_w[r]), .side_i(side_w[r]),
      .vld_o(vld_w[r+1]), .st_o(st_w[r+1]), .blk_o(blk_w[r+1]),
      .side_o(side_w[r+1])
    );
  end

  assign h_last = side_w[mdcr_pkg::ROUNDS][mdcr_pkg::RSIDE_W-1:mdcr_pkg::SIDE_W];
  assign h_o.a  = h_last.a + st_w[mdcr_pkg::ROUNDS].a;
  assign h_o.b  = h_last.b + st_w[mdcr_pkg::ROUNDS].b;
  assign h_o.c  = h_last.c + st_w[mdcr_pkg::ROUNDS].c;
  assign h_o.d  = h_last.d + st_w[mdcr_pkg::ROUNDS].d;
  assign vld_o  = vld_w[mdcr_pkg::ROUNDS];
  assign side_o = side_w[mdcr_pkg::ROUNDS][mdcr_pkg::SIDE_W-1:0];

endmodule
`default_nettype wire
